### rtl/core/oil_pkg.sv
`default_nettype none

package oil_pkg;

  typedef enum logic [3:0] {
    CMD_PUSH_TOP    = 4'd0,
    CMD_PUSH_BOTTOM = 4'd1,
    CMD_INSERT_AT   = 4'd2,
    CMD_POP_TOP     = 4'd3,
    CMD_POP_BOTTOM  = 4'd4,
    CMD_POP_AT      = 4'd5,
    CMD_REMOVE_ID   = 4'd6,
    CMD_FIND        = 4'd7,
    CMD_MOVE_UP     = 4'd8,
    CMD_MOVE_DOWN   = 4'd9,
    CMD_READ_AT     = 4'd10
  } cmd_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_NONE  = 2'd1,
    STAT_FULL  = 2'd2,
    STAT_RANGE = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_INSERT,
    S_REMOVE,
    S_SWAP_RD,
    S_SWAP_WB,
    S_SWAP_WA,
    S_READ
  } state_t;

  typedef struct packed {
    logic [3:0]  command;
    logic [31:0] window_id;
    logic [3:0]  position;
  } oil_in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [3:0]  found_position;
    logic [31:0] id_out;
    logic [4:0]  entry_count;
  } oil_out_t;

endpackage

`default_nettype wire

### rtl/core/ordered_id_list_unit.sv
// Rejected commands answer in the cycle after start; read_at does one memory read.
// find, insert and the pops walk the list one entry at a time; remove_id searches
// and then shifts; moves search and then swap. One command at a time; the single
// read and single write port of the entry memory set the pace (one entry a cycle).
// Reset: synchronous rst_n clears the count and control; the memory holds
// stale data and needs no clearing pass. Results are strobed, never stalled.
`default_nettype none

module ordered_id_list_unit #(
  parameter int DEPTH    = 16,
  parameter int ID_WIDTH = 32
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire oil_pkg::oil_in_t  in_item,
  output logic                   out_valid,
  output oil_pkg::oil_out_t      out_item
);

  import oil_pkg::*;

  localparam int IW = ID_WIDTH;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int PW = (CW > 4) ? CW : 4;

  state_t          state_r, state_nxt;
  logic [3:0]      cmd_r, cmd_nxt;
  logic [IW-1:0]   id_r, id_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [CW-1:0]   p_r, p_nxt;
  logic [CW-1:0]   q_r, q_nxt;
  logic [CW-1:0]   idx_r, idx_nxt;
  logic            pend_r, pend_nxt;
  logic [CW-1:0]   pend_addr_r, pend_addr_nxt;
  logic            cap_r, cap_nxt;
  logic [IW-1:0]   idout_r, idout_nxt;
  logic            out_valid_r, out_valid_nxt;
  oil_out_t        out_r, out_nxt;

  logic            ram_we, ram_re;
  logic [AW-1:0]   ram_waddr, ram_raddr;
  logic [IW-1:0]   ram_wdata, ram_rdata;

  logic [IW-1:0]   in_id;
  logic [PW-1:0]   cnt_x, pos_x, p_sel;

  function automatic oil_out_t mk_out(status_t st, logic [CW-1:0] fp,
                                      logic [IW-1:0] id, logic [CW-1:0] cnt);
    oil_out_t o;
    o.status         = st;
    o.found_position = 4'(fp);
    o.id_out         = 32'(id);
    o.entry_count    = 5'(cnt);
    return o;
  endfunction

  assign in_id = IW'(in_item.window_id);
  assign cnt_x = PW'(cnt_r);
  assign pos_x = PW'(in_item.position);

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  oil_ram #(
    .DW    (IW),
    .AW    (AW),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      cap_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      cap_r       <= cap_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    p_r         <= p_nxt;
    q_r         <= q_nxt;
    idx_r       <= idx_nxt;
    pend_addr_r <= pend_addr_nxt;
    idout_r     <= idout_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    cnt_nxt       = cnt_r;
    p_nxt         = p_r;
    q_nxt         = q_r;
    idx_nxt       = idx_r;
    pend_nxt      = pend_r;
    pend_addr_nxt = pend_addr_r;
    cap_nxt       = cap_r;
    idout_nxt     = idout_r;
    out_valid_nxt = 1'b0;
    out_nxt       = out_r;
    ram_we        = 1'b0;
    ram_waddr     = '0;
    ram_wdata     = '0;
    ram_re        = 1'b0;
    ram_raddr     = '0;
    p_sel         = '0;

    case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt  = in_item.command;
          id_nxt   = in_id;
          pend_nxt = 1'b0;
          cap_nxt  = 1'b0;
          case (in_item.command)
            CMD_PUSH_TOP, CMD_PUSH_BOTTOM, CMD_INSERT_AT: begin
              if (in_item.command == CMD_PUSH_TOP) begin
                p_sel = '0;
              end else if (in_item.command == CMD_PUSH_BOTTOM) begin
                p_sel = cnt_x;
              end else begin
                p_sel = pos_x;
              end
              if (cnt_r == CW'(DEPTH)) begin
                out_valid_nxt = 1'b1;
                out_nxt = mk_out(STAT_FULL, '0, '0, cnt_r);
              end else if (p_sel > cnt_x) begin
                out_valid_nxt = 1'b1;
                out_nxt = mk_out(STAT_RANGE, '0, '0, cnt_r);
              end else begin
                p_nxt     = CW'(p_sel);
                idx_nxt   = cnt_r;
                state_nxt = S_INSERT;
              end
            end
            CMD_POP_TOP, CMD_POP_BOTTOM, CMD_POP_AT: begin
              if (in_item.command == CMD_POP_TOP) begin
                p_sel = '0;
              end else if (in_item.command == CMD_POP_BOTTOM) begin
                p_sel = cnt_x - PW'(1);
              end else begin
                p_sel = pos_x;
              end
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = mk_out(STAT_NONE, '0, '0, cnt_r);
              end else if (p_sel >= cnt_x) begin
                out_valid_nxt = 1'b1;
                out_nxt = mk_out(STAT_RANGE, '0, '0, cnt_r);
              end else begin
                p_nxt     = CW'(p_sel);
                idx_nxt   = CW'(p_sel);
                state_nxt = S_REMOVE;
              end
            end
            CMD_REMOVE_ID, CMD_FIND, CMD_MOVE_UP, CMD_MOVE_DOWN: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = mk_out(STAT_NONE, '0, '0, cnt_r);
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SEARCH;
              end
            end
            CMD_READ_AT: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt = mk_out(STAT_NONE, '0, '0, cnt_r);
              end else if (pos_x >= cnt_x) begin
                out_valid_nxt = 1'b1;
                out_nxt = mk_out(STAT_RANGE, '0, '0, cnt_r);
              end else begin
                ram_re    = 1'b1;
                ram_raddr = AW'(in_item.position);
                p_nxt     = CW'(pos_x);
                state_nxt = S_READ;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt = mk_out(STAT_RANGE, '0, '0, cnt_r);
            end
          endcase
        end
      end

      S_SEARCH: begin
        if (idx_r < cnt_r) begin
          ram_re        = 1'b1;
          ram_raddr     = idx_r[AW-1:0];
          idx_nxt       = idx_r + CW'(1);
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r;
        end else begin
          pend_nxt = 1'b0;
        end
        if (pend_r && ram_rdata == id_r) begin
          pend_nxt = 1'b0;
          cap_nxt  = 1'b0;
          case (cmd_r)
            CMD_FIND: begin
              out_valid_nxt = 1'b1;
              out_nxt   = mk_out(STAT_OK, pend_addr_r, '0, cnt_r);
              state_nxt = S_IDLE;
            end
            CMD_REMOVE_ID: begin
              p_nxt     = pend_addr_r;
              idx_nxt   = pend_addr_r;
              state_nxt = S_REMOVE;
            end
            CMD_MOVE_UP: begin
              if (pend_addr_r == '0) begin
                out_valid_nxt = 1'b1;
                out_nxt   = mk_out(STAT_RANGE, '0, '0, cnt_r);
                state_nxt = S_IDLE;
              end else begin
                p_nxt     = pend_addr_r;
                q_nxt     = pend_addr_r - CW'(1);
                state_nxt = S_SWAP_RD;
              end
            end
            CMD_MOVE_DOWN: begin
              if (pend_addr_r + CW'(1) >= cnt_r) begin
                out_valid_nxt = 1'b1;
                out_nxt   = mk_out(STAT_RANGE, '0, '0, cnt_r);
                state_nxt = S_IDLE;
              end else begin
                p_nxt     = pend_addr_r;
                q_nxt     = pend_addr_r + CW'(1);
                state_nxt = S_SWAP_RD;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_nxt   = mk_out(STAT_RANGE, '0, '0, cnt_r);
              state_nxt = S_IDLE;
            end
          endcase
        end else if (!pend_r && !(idx_r < cnt_r)) begin
          out_valid_nxt = 1'b1;
          out_nxt   = mk_out(STAT_NONE, '0, '0, cnt_r);
          state_nxt = S_IDLE;
        end
      end

      // shift down from the bottom: read j-1, write it to j in the next cycle
      S_INSERT: begin
        if (pend_r) begin
          ram_we    = 1'b1;
          ram_waddr = pend_addr_r[AW-1:0];
          ram_wdata = ram_rdata;
        end
        if (idx_r > p_r) begin
          ram_re        = 1'b1;
          ram_raddr     = AW'(idx_r - CW'(1));
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r;
          idx_nxt       = idx_r - CW'(1);
        end else if (!pend_r) begin
          ram_we        = 1'b1;
          ram_waddr     = p_r[AW-1:0];
          ram_wdata     = id_r;
          cnt_nxt       = cnt_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt   = mk_out(STAT_OK, p_r, '0, cnt_r + CW'(1));
          state_nxt = S_IDLE;
        end else begin
          pend_nxt = 1'b0;
        end
      end

      // first read captures the removed entry, later reads shift up by one
      S_REMOVE: begin
        if (pend_r) begin
          if (cap_r) begin
            idout_nxt = ram_rdata;
          end else begin
            ram_we    = 1'b1;
            ram_waddr = pend_addr_r[AW-1:0];
            ram_wdata = ram_rdata;
          end
        end
        if (idx_r < cnt_r) begin
          ram_re        = 1'b1;
          ram_raddr     = idx_r[AW-1:0];
          pend_nxt      = 1'b1;
          pend_addr_nxt = idx_r - CW'(1);
          cap_nxt       = (idx_r == p_r);
          idx_nxt       = idx_r + CW'(1);
        end else if (!pend_r) begin
          cnt_nxt       = cnt_r - CW'(1);
          out_valid_nxt = 1'b1;
          out_nxt   = mk_out(STAT_OK, p_r, idout_r, cnt_r - CW'(1));
          state_nxt = S_IDLE;
        end else begin
          pend_nxt = 1'b0;
          cap_nxt  = 1'b0;
        end
      end

      S_SWAP_RD: begin
        ram_re    = 1'b1;
        ram_raddr = q_r[AW-1:0];
        state_nxt = S_SWAP_WB;
      end

      S_SWAP_WB: begin
        ram_we    = 1'b1;
        ram_waddr = q_r[AW-1:0];
        ram_wdata = id_r;
        state_nxt = S_SWAP_WA;
      end

      S_SWAP_WA: begin
        ram_we        = 1'b1;
        ram_waddr     = p_r[AW-1:0];
        ram_wdata     = ram_rdata;
        out_valid_nxt = 1'b1;
        out_nxt   = mk_out(STAT_OK, q_r, '0, cnt_r);
        state_nxt = S_IDLE;
      end

      S_READ: begin
        out_valid_nxt = 1'b1;
        out_nxt   = mk_out(STAT_OK, p_r, ram_rdata, cnt_r);
        state_nxt = S_IDLE;
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

### rtl/core/oil_ram.sv
`default_nettype none

module oil_ram #(
  parameter int DW    = 32,
  parameter int AW    = 4,
  parameter int DEPTH = 16
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [DW-1:0] wdata,
  input  wire logic          re,
  input  wire logic [AW-1:0] raddr,
  output logic      [DW-1:0] rdata
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

### rtl/core/oil_checker.sv
`default_nettype none

module oil_checker #(
  parameter int DEPTH = 16
) (
  input wire logic              clk,
  input wire logic              rst_n,
  input wire logic              start,
  input wire logic              busy,
  input wire logic              out_valid,
  input wire oil_pkg::oil_out_t out_item
);

  import oil_pkg::*;

  // an accepted beat either answers at once or holds the unit busy
  a_accept_acts: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted command neither answered nor started");

  a_no_result_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobed while busy");

  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != STAT_OK) |->
      (out_item.found_position == 4'd0 && out_item.id_out == 32'd0))
    else $error("failed command returned position or id");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STAT_FULL) |-> out_item.entry_count == 5'(DEPTH))
    else $error("full status with count below depth");

  a_in_stable_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status == STAT_OK) |-> $past(busy) || $past(start))
    else $error("result without a command");

endmodule

bind ordered_id_list_unit oil_checker #(.DEPTH(DEPTH)) u_oil_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

`default_nettype wire

### dv/tb.sv
`timescale 1ns / 1ps

module tb;
  import oil_pkg::*;

  localparam int LIST_DEPTH = 16;
  localparam int POOL_SIZE = 24;
  localparam int ITEMS_PER_PHASE = 267;
  localparam logic [3:0] CMD_UNUSED_FIRST = 4'(CMD_READ_AT + 1);

  class id_list_shadow;
    logic [31:0] slots[LIST_DEPTH];
    int used;
    oil_out_t expected_replies[$];
    int mismatches;

    function new();
      used = 0;
      mismatches = 0;
    endfunction

    function int locate(logic [31:0] id);
      for (int i = 0; i < used; i++) begin
        if (slots[i] == id) return i;
      end
      return -1;
    endfunction

    function void place(int p, logic [31:0] id);
      for (int i = used; i > p; i--) slots[i] = slots[i - 1];
      slots[p] = id;
      used++;
    endfunction

    function logic [31:0] take(int p);
      logic [31:0] v;
      v = slots[p];
      for (int i = p; i + 1 < used; i++) slots[i] = slots[i + 1];
      used--;
      return v;
    endfunction

    // Accepted command beat: update the shadow list, queue the reply.
    function void apply_command(oil_in_t item);
      oil_out_t r;
      int p;
      int hit;
      int b;
      logic [31:0] t;
      r = '0;
      p = item.position;
      case (item.command)
        CMD_PUSH_TOP, CMD_PUSH_BOTTOM, CMD_INSERT_AT: begin
          if (used >= LIST_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            if (item.command == CMD_PUSH_TOP) p = 0;
            else if (item.command == CMD_PUSH_BOTTOM) p = used;
            if (p > used) begin
              r.status = STAT_RANGE;
            end else begin
              place(p, item.window_id);
              r.found_position = 4'(p);
            end
          end
        end
        CMD_POP_TOP, CMD_POP_BOTTOM, CMD_POP_AT: begin
          if (used == 0) begin
            r.status = STAT_NONE;
          end else begin
            if (item.command == CMD_POP_TOP) p = 0;
            else if (item.command == CMD_POP_BOTTOM) p = used - 1;
            if (p >= used) begin
              r.status = STAT_RANGE;
            end else begin
              r.id_out = take(p);
              r.found_position = 4'(p);
            end
          end
        end
        CMD_REMOVE_ID, CMD_FIND: begin
          hit = locate(item.window_id);
          if (hit < 0) begin
            r.status = STAT_NONE;
          end else begin
            if (item.command == CMD_REMOVE_ID) r.id_out = take(hit);
            r.found_position = 4'(hit);
          end
        end
        CMD_MOVE_UP, CMD_MOVE_DOWN: begin
          hit = locate(item.window_id);
          if (hit < 0) begin
            r.status = STAT_NONE;
          end else begin
            b = (item.command == CMD_MOVE_UP) ? hit - 1 : hit + 1;
            if (b < 0 || b >= used) begin
              r.status = STAT_RANGE;
            end else begin
              t = slots[hit];
              slots[hit] = slots[b];
              slots[b] = t;
              r.found_position = 4'(b);
            end
          end
        end
        CMD_READ_AT: begin
          if (used == 0) begin
            r.status = STAT_NONE;
          end else if (p >= used) begin
            r.status = STAT_RANGE;
          end else begin
            r.id_out = slots[p];
            r.found_position = 4'(p);
          end
        end
        default: r.status = STAT_RANGE;
      endcase
      r.entry_count = 5'(used);
      expected_replies.push_back(r);
    endfunction

    task report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("%0t: mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
      mismatches++;
    endtask

    task check_reply(oil_out_t got);
      oil_out_t want;
      if (expected_replies.size() == 0) begin
        report_mismatch("unexpected reply beat", 32'(got), 32'd0);
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.found_position !== want.found_position)
        report_mismatch("found_position", 32'(got.found_position), 32'(want.found_position));
      if (got.id_out !== want.id_out)
        report_mismatch("id_out", got.id_out, want.id_out);
      if (got.entry_count !== want.entry_count)
        report_mismatch("entry_count", 32'(got.entry_count), 32'(want.entry_count));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  oil_in_t in_item = '0;
  logic out_valid;
  oil_out_t out_item;

  id_list_shadow shadow;
  logic [31:0] id_pool[POOL_SIZE];

  always #6 clk = ~clk;

  ordered_id_list_unit DUT (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_item(in_item),
    .out_valid(out_valid),
    .out_item(out_item)
  );

  always @(posedge clk) begin
    if (rst_n && out_valid) shadow.check_reply(out_item);
  end

  function automatic oil_in_t make_cmd(logic [3:0] cmd, logic [31:0] id, logic [3:0] pos);
    oil_in_t c;
    c.command = cmd;
    c.window_id = id;
    c.position = pos;
    return c;
  endfunction

  function automatic oil_in_t random_cmd(int push_bias);
    int r;
    logic [3:0] cmd;
    logic [31:0] id;
    logic [3:0] pos;
    r = $urandom_range(99);
    if (r < 2) cmd = 4'(CMD_UNUSED_FIRST + $urandom_range(4));
    else if (r < push_bias) cmd = 4'(CMD_PUSH_TOP + $urandom_range(2));
    else cmd = 4'(CMD_POP_TOP + $urandom_range(7));
    id = ($urandom_range(99) < 85) ? id_pool[$urandom_range(POOL_SIZE - 1)] : 32'($urandom);
    pos = ($urandom_range(9) < 7) ? 4'($urandom_range(shadow.used)) : 4'($urandom_range(15));
    return make_cmd(cmd, id, pos);
  endfunction

  // Drive one command beat; idle_pct is the chance of a gap cycle before it.
  task automatic send_cmd(oil_in_t item, int idle_pct);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy);
    shadow.apply_command(item);
  endtask

  initial begin
    oil_in_t directed[$];
    oil_in_t item;
    int phase_idle[3];
    int sent;
    int bias;
    int stretch_idle;
    shadow = new();
    id_pool[0] = 32'h0;
    id_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < POOL_SIZE; i++) id_pool[i] = 32'($urandom);
    phase_idle[0] = 36;
    phase_idle[1] = 82;
    phase_idle[2] = 0;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // empty list, edge positions, edge moves, absent ids, unused commands
    directed.push_back(make_cmd(CMD_POP_TOP, 32'h0, 4'd0));
    directed.push_back(make_cmd(CMD_READ_AT, 32'h0, 4'd0));
    directed.push_back(make_cmd(CMD_POP_AT, 32'h0, 4'd15));
    directed.push_back(make_cmd(CMD_FIND, 32'hFFFF_FFFF, 4'd0));
    directed.push_back(make_cmd(CMD_PUSH_TOP, 32'hFFFF_FFFF, 4'd15));
    directed.push_back(make_cmd(CMD_PUSH_BOTTOM, 32'h0, 4'd15));
    directed.push_back(make_cmd(CMD_INSERT_AT, 32'hA5A5_5A5A, 4'd1));
    directed.push_back(make_cmd(CMD_INSERT_AT, 32'h1234_5678, 4'd5));
    directed.push_back(make_cmd(CMD_INSERT_AT, 32'h0, 4'd3));
    directed.push_back(make_cmd(CMD_READ_AT, 32'h0, 4'd15));
    directed.push_back(make_cmd(CMD_READ_AT, 32'h0, 4'd2));
    directed.push_back(make_cmd(CMD_MOVE_UP, 32'hFFFF_FFFF, 4'd0));
    directed.push_back(make_cmd(CMD_MOVE_DOWN, 32'h0, 4'd0));
    directed.push_back(make_cmd(CMD_MOVE_DOWN, 32'hA5A5_5A5A, 4'd0));
    directed.push_back(make_cmd(CMD_MOVE_UP, 32'h0, 4'd0));
    directed.push_back(make_cmd(CMD_MOVE_UP, 32'h1234_5678, 4'd0));
    directed.push_back(make_cmd(CMD_FIND, 32'h0, 4'd0));
    directed.push_back(make_cmd(CMD_REMOVE_ID, 32'h1234_5678, 4'd0));
    directed.push_back(make_cmd(CMD_REMOVE_ID, 32'hA5A5_5A5A, 4'd0));
    directed.push_back(make_cmd(CMD_POP_AT, 32'h0, 4'd1));
    directed.push_back(make_cmd(CMD_POP_BOTTOM, 32'h0, 4'd0));
    directed.push_back(make_cmd(4'(CMD_UNUSED_FIRST), 32'hFFFF_FFFF, 4'd15));
    directed.push_back(make_cmd(4'hF, 32'h0, 4'd0));
    directed.push_back(make_cmd(CMD_POP_TOP, 32'h0, 4'd0));
    foreach (directed[i]) send_cmd(directed[i], 0);

    // blocks of 40 beats with a drifting push bias so the list fills and drains
    for (int ph = 0; ph < 3; ph++) begin
      sent = 0;
      bias = 40;
      stretch_idle = phase_idle[ph];
      while (sent < ITEMS_PER_PHASE) begin
        if (sent % 40 == 0) begin
          case ($urandom_range(2))
            0: bias = 75;
            1: bias = 40;
            default: bias = 15;
          endcase
          stretch_idle = ($urandom_range(3) == 0) ? 0 : phase_idle[ph];
        end
        item = random_cmd(bias);
        send_cmd(item, stretch_idle);
        if (item.command < CMD_UNUSED_FIRST) sent++;
      end
    end
    start <= 1'b0;

    while (shadow.expected_replies.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
    if (shadow.mismatches == 0 && shadow.expected_replies.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
